// ----- hw/rtl/gcm_pkg.sv -----
// Package for the gate clock multiplier.
// Holds the widths, reset values, register map and controller-to-datapath command type.
// No dependencies.
package gcm_pkg;

    localparam int COUNT_WIDTH  = 24;
    localparam int RESET_PERIOD = 48000;
    localparam int CHANNELS     = 5;
    localparam int CHAN_W       = 3;
    localparam int TALLY_W      = 5;
    localparam int SAMPLE_W     = 16;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int TDATA_IN_W   = 16;
    localparam int TDATA_OUT_W  = 8;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] PERIOD_RESET = COUNT_WIDTH'(RESET_PERIOD);
    localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RESET = 16'sd4096;
    localparam logic REG_IDX_THRESHOLD = 1'b0;
    localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(CHANNELS - 1);

    typedef struct packed {
        logic              capture;
        logic              edge_step;
        logic              chan_en;
        logic [CHAN_W-1:0] chan;
        logic              finish;
    } gcm_cmd_t;

endpackage

// ----- hw/rtl/gcm_datapath.sv -----
// Datapath of the gate clock multiplier: edge detector, sample counter, period,
// and a shared interval/phase unit that serves one gate channel per cycle.
// Depends on gcm_pkg.
module gcm_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gcm_pkg::gcm_cmd_t                   cmd,
    input  logic signed [gcm_pkg::SAMPLE_W-1:0] sample,
    input  logic signed [gcm_pkg::SAMPLE_W-1:0] threshold,
    output logic [gcm_pkg::CHANNELS-1:0]        gates
);
    import gcm_pkg::*;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       was_high_reg;
    logic [COUNT_WIDTH-1:0]     count_reg;
    logic [COUNT_WIDTH-1:0]     period_reg;
    logic [COUNT_WIDTH-1:0]     phase_reg [CHANNELS];
    logic [TALLY_W-1:0]         tally_reg [CHANNELS];
    logic [CHANNELS-1:0]        gates_reg;

    logic                       high;
    logic [COUNT_WIDTH-1:0]     shifted;
    logic [COUNT_WIDTH-1:0]     interval;
    logic [COUNT_WIDTH-1:0]     phase;
    logic [COUNT_WIDTH-1:0]     phase_inc;
    logic [TALLY_W-1:0]         tally;
    logic [TALLY_W-1:0]         limit;
    logic                       fire;
    logic                       advance;
    logic [COUNT_WIDTH-1:0]     phase_next;

    always_comb
    begin
        high       = sample_reg > threshold;
        shifted    = period_reg >> cmd.chan;
        interval   = (shifted == '0) ? COUNT_WIDTH'(1) : shifted;
        phase      = phase_reg[cmd.chan];
        tally      = tally_reg[cmd.chan];
        limit      = TALLY_W'(1) << cmd.chan;
        fire       = (phase == '0) && (tally < limit);
        advance    = count_reg != COUNT_MAX;
        phase_inc  = phase + COUNT_WIDTH'(1);
        phase_next = phase;
        if (advance)
        begin
            phase_next = (phase_inc == interval) ? '0 : phase_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_high_reg <= 1'b0;
            count_reg    <= '0;
            period_reg   <= PERIOD_RESET;
            gates_reg    <= '0;
            for (int k = 0; k < CHANNELS; k++)
            begin
                phase_reg[k] <= '0;
                tally_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.edge_step)
            begin
                was_high_reg <= high;
                if (high && !was_high_reg)
                begin
                    period_reg <= count_reg;
                    count_reg  <= '0;
                    for (int k = 0; k < CHANNELS; k++)
                    begin
                        phase_reg[k] <= '0;
                        tally_reg[k] <= '0;
                    end
                end
            end
            if (cmd.chan_en)
            begin
                phase_reg[cmd.chan] <= phase_next;
                gates_reg[cmd.chan] <= fire;
                if (fire)
                begin
                    tally_reg[cmd.chan] <= tally + TALLY_W'(1);
                end
            end
            if (cmd.finish && advance)
            begin
                count_reg <= count_reg + COUNT_WIDTH'(1);
            end
        end
    end

    assign gates = gates_reg;

endmodule

// ----- hw/rtl/gcm_controller.sv -----
// Controller of the gate clock multiplier: sequences capture, edge step,
// five channel steps and the hand-off to the output register.
// Depends on gcm_pkg.
module gcm_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_free,
    output gcm_pkg::gcm_cmd_t cmd
);
    import gcm_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EDGE, S_CHAN, S_HOLD} state_t;

    state_t            state_reg;
    logic [CHAN_W-1:0] chan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chan_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_EDGE;
                    end
                end
                S_EDGE:
                begin
                    chan_reg  <= '0;
                    state_reg <= S_CHAN;
                end
                S_CHAN:
                begin
                    if (chan_reg == LAST_CHAN)
                    begin
                        state_reg <= S_HOLD;
                    end
                    else
                    begin
                        chan_reg <= chan_reg + CHAN_W'(1);
                    end
                end
                S_HOLD:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        in_ready      = state_reg == S_IDLE;
        cmd.capture   = in_ready && in_valid;
        cmd.edge_step = state_reg == S_EDGE;
        cmd.chan_en   = state_reg == S_CHAN;
        cmd.chan      = chan_reg;
        cmd.finish    = (state_reg == S_HOLD) && out_free;
    end

endmodule

// ----- hw/rtl/gate_clock_multiplier.sv -----
// Top level of the gate clock multiplier: configuration register, controller,
// datapath and output register.  Depends on gcm_pkg, gcm_controller and gcm_datapath.
//
//   channel   direction  contents
//   s_*       in         clock_sample, one word per sample
//   m_*       out        five gate bits, one word per sample
//   APB       in/out     gate_threshold at byte address 0
//
// A sample passes through acceptance, the edge step, a step for each of the
// five channels in the shared interval and phase unit, and the hand-off to the
// output register; the hand-off waits while that register is still full.
// A new sample is accepted while a result waits in the output register.
// Reset clears all counters and tallies and loads the reset period at once.
module gate_clock_multiplier (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Bits 15:0 clock_sample.
    input  logic [gcm_pkg::TDATA_IN_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Bit 0 gate_whole, 1 gate_half, 2 gate_quarter, 3 gate_eighth,
    // 4 gate_sixteenth, 7:5 zero.
    output logic [gcm_pkg::TDATA_OUT_W-1:0]   m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gcm_pkg::PADDR_W-1:0]       paddr,
    input  logic [gcm_pkg::PDATA_W-1:0]       pwdata,
    output logic [gcm_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready
);
    import gcm_pkg::*;

    logic signed [SAMPLE_W-1:0] threshold_reg;
    logic                       out_valid_reg;
    logic [CHANNELS-1:0]        out_gates_reg;
    logic                       out_free;
    logic [CHANNELS-1:0]        gates;
    gcm_cmd_t                   cmd;

    assign pready   = 1'b1;
    assign prdata   = PDATA_W'(threshold_reg);
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready
                && (paddr[PADDR_W-1] == REG_IDX_THRESHOLD))
            begin
                threshold_reg <= pwdata[SAMPLE_W-1:0];
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_gates_reg <= gates;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_OUT_W'(out_gates_reg);

    gcm_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .cmd      (cmd)
    );

    gcm_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sample    (s_tdata[SAMPLE_W-1:0]),
        .threshold (threshold_reg),
        .gates     (gates)
    );

endmodule

// ----- test/gcm_gate_checker.sv -----
// Checker for the gate clock multiplier: watches the sample, gate and APB channels,
// predicts every gate word from its own copy of the block state and compares.
// Depends on gcm_pkg.
module gcm_gate_checker
    import gcm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    // Bits 15:0 clock_sample.
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // Bit 0 gate_whole, 1 gate_half, 2 gate_quarter, 3 gate_eighth,
    // 4 gate_sixteenth, 7:5 zero.
    input  logic [TDATA_OUT_W-1:0] m_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [PDATA_W-1:0]     pwdata,
    input  logic [PDATA_W-1:0]     prdata,
    input  logic                   pready,
    output int                     fail_count,
    output int                     pending,
    output int                     words_checked,
    output int                     edges_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [PADDR_W-1:0] THRESHOLD_ADDR = PADDR_W'(int'(REG_IDX_THRESHOLD) * 4);

    string gate_names [CHANNELS] = '{"gate_whole", "gate_half", "gate_quarter",
                                     "gate_eighth", "gate_sixteenth"};

    logic signed [SAMPLE_W-1:0] gate_threshold;
    logic                       input_was_high;
    logic [COUNT_WIDTH-1:0]     sample_count;
    logic [COUNT_WIDTH-1:0]     measured_period;
    logic [TALLY_W-1:0]         pulses_given [CHANNELS];
    logic [CHANNELS-1:0]        gate_words_due [$];
    logic [CHANNELS-1:0]        due_word;
    logic [CHANNELS-1:0]        next_word;

    task automatic step_gates(input logic signed [SAMPLE_W-1:0] sample,
                              output logic [CHANNELS-1:0] gates);
        logic                   high;
        logic [COUNT_WIDTH-1:0] interval;
        int                     k;
        high = sample > gate_threshold;
        if (high && !input_was_high) begin
            measured_period = sample_count;
            sample_count = '0;
            for (k = 0; k < CHANNELS; k++) begin
                pulses_given[k] = '0;
            end
            edges_seen++;
        end
        input_was_high = high;
        for (k = 0; k < CHANNELS; k++) begin
            interval = measured_period >> k;
            if (interval == '0) begin
                interval = COUNT_WIDTH'(1);
            end
            gates[k] = (sample_count % interval == '0) &&
                       (pulses_given[k] < TALLY_W'(1 << k));
            if (gates[k]) begin
                pulses_given[k] = pulses_given[k] + 1'b1;
            end
        end
        if (sample_count != COUNT_MAX) begin
            sample_count = sample_count + 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            gate_threshold  = THRESHOLD_RESET;
            input_was_high  = 1'b0;
            sample_count    = '0;
            measured_period = PERIOD_RESET;
            for (int k = 0; k < CHANNELS; k++) begin
                pulses_given[k] = '0;
            end
            gate_words_due.delete();
            fail_count    = 0;
            words_checked = 0;
            edges_seen    = 0;
            pending      <= 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (gate_words_due.size() == 0) begin
                    $error("m_tdata: expected no word, got %h", m_tdata);
                    fail_count++;
                end
                else begin
                    due_word = gate_words_due.pop_front();
                    for (int k = 0; k < CHANNELS; k++) begin
                        if (m_tdata[k] !== due_word[k]) begin
                            $error("%s: expected %0d, got %0d", gate_names[k],
                                   due_word[k], m_tdata[k]);
                            fail_count++;
                        end
                    end
                    if (m_tdata[TDATA_OUT_W-1:CHANNELS] !== '0) begin
                        $error("m_tdata padding: expected 0, got %0d",
                               m_tdata[TDATA_OUT_W-1:CHANNELS]);
                        fail_count++;
                    end
                    words_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                step_gates(s_tdata[SAMPLE_W-1:0], next_word);
                gate_words_due.push_back(next_word);
            end
            if (psel && penable && pready && paddr == THRESHOLD_ADDR) begin
                if (pwrite) begin
                    gate_threshold = pwdata[SAMPLE_W-1:0];
                end
                else if (prdata[SAMPLE_W-1:0] !== gate_threshold) begin
                    $error("gate_threshold: expected %0d, got %0d", gate_threshold,
                           $signed(prdata[SAMPLE_W-1:0]));
                    fail_count++;
                end
            end
            pending <= gate_words_due.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
// Top of the gate clock multiplier testbench: clock, reset, sample and APB stimulus,
// random back-pressure and the verdict.  Depends on gcm_pkg, gate_clock_multiplier
// and gcm_gate_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import gcm_pkg::*;

    localparam int REG_IDX_SPARE  = 1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int END_PAUSE      = 40;
    localparam int PHASE_ITEMS    = 142;
    localparam logic [PADDR_W-1:0] THRESHOLD_ADDR = PADDR_W'(int'(REG_IDX_THRESHOLD) * 4);
    localparam logic [PADDR_W-1:0] SPARE_ADDR     = PADDR_W'(REG_IDX_SPARE * 4);

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // Bits 15:0 clock_sample.
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // Bit 0 gate_whole, 1 gate_half, 2 gate_quarter, 3 gate_eighth,
    // 4 gate_sixteenth, 7:5 zero.
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    int   fail_count;
    int   pending;
    int   words_checked;
    int   edges_seen;
    int   samples_sent;
    int   settings_used;
    int   threshold_now;
    int   idle_cycles;
    logic no_idle;

    logic [TDATA_IN_W-1:0] directed_samples [21] = '{
        16'h8000, 16'h0000, 16'h1000, 16'h1001, 16'h7FFF, 16'h7FFF, 16'h1001,
        16'h1000, 16'h1001, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h5555, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000};

    gate_clock_multiplier dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    gcm_gate_checker gate_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked),
        .edges_seen    (edges_seen)
    );

    always #1 clk = ~clk;

    task automatic send_sample(input logic [TDATA_IN_W-1:0] sample);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        samples_sent++;
    endtask

    task automatic apb_access(input logic write, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [TDATA_IN_W-1:0] level_sample(input logic want_high, input int thr);
        int span;
        int v;
        if (want_high && thr < 32767)
        begin
            span = 32767 - thr;
            v = ($urandom_range(0, 7) == 0) ? thr + 1 : thr + 1 + int'($urandom % span);
        end
        else
        begin
            span = thr + 32769;
            v = ($urandom_range(0, 7) == 0) ? thr : -32768 + int'($urandom % span);
        end
        return v[TDATA_IN_W-1:0];
    endfunction

    task automatic set_threshold(input int thr);
        settle();
        apb_access(1'b1, THRESHOLD_ADDR, {16'($urandom), 16'(thr)});
        apb_access(1'b0, THRESHOLD_ADDR, '0);
        threshold_now = thr;
        settings_used++;
    endtask

    // Mostly square waves with random lengths and levels, the rest raw noise.
    task automatic random_run(input int quota);
        int sent;
        int low_len;
        int high_len;
        int k;
        sent = 0;
        while (sent < quota)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                no_idle = ~no_idle;
            end
            if ($urandom_range(0, 4) == 0)
            begin
                low_len = $urandom_range(1, 8);
                for (k = 0; k < low_len; k++)
                begin
                    send_sample(16'($urandom));
                end
                sent += low_len;
            end
            else
            begin
                low_len  = $urandom_range(1, 24);
                high_len = $urandom_range(1, 24);
                if ($urandom_range(0, 19) == 0)
                begin
                    low_len = $urandom_range(40, 120);
                end
                for (k = 0; k < low_len; k++)
                begin
                    send_sample(level_sample(1'b0, threshold_now));
                end
                for (k = 0; k < high_len; k++)
                begin
                    send_sample(level_sample(1'b1, threshold_now));
                end
                sent += low_len + high_len;
            end
        end
    endtask

    initial
    begin : receiver
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no word moved for %0d cycles.", WATCHDOG_LIMIT);
        $display("[gate_clock_multiplier] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        samples_sent  = 0;
        settings_used = 1;
        threshold_now = int'(THRESHOLD_RESET);
        no_idle       = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset period on the first word, short and held-high periods, level edges.
        foreach (directed_samples[i])
        begin
            send_sample(directed_samples[i]);
        end
        settle();
        apb_access(1'b1, SPARE_ADDR, $urandom);
        apb_access(1'b0, THRESHOLD_ADDR, '0);

        set_threshold(32767);
        random_run(PHASE_ITEMS);
        set_threshold(-32768);
        random_run(PHASE_ITEMS);
        set_threshold(0);
        random_run(PHASE_ITEMS);
        set_threshold(-1);
        random_run(PHASE_ITEMS);
        set_threshold(int'($urandom_range(0, 65535)) - 32768);
        random_run(PHASE_ITEMS);
        set_threshold(int'($urandom_range(0, 65535)) - 32768);
        random_run(PHASE_ITEMS);
        set_threshold(int'(THRESHOLD_RESET));
        random_run(PHASE_ITEMS);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (END_PAUSE) @(posedge clk);

        $display("Summary: %0d samples over %0d threshold settings, %0d clock edges predicted.",
                 samples_sent, settings_used, edges_seen);
        $display("Summary: %0d gate words compared, %0d mismatches.", words_checked, fail_count);
        if (fail_count == 0)
            $display("[gate_clock_multiplier] OK");
        else
            $display("[gate_clock_multiplier] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/gcm_pkg.sv
hw/rtl/gcm_datapath.sv
hw/rtl/gcm_controller.sv
hw/rtl/gate_clock_multiplier.sv
test/gcm_gate_checker.sv
test/tb_top.sv
